@@ sv/masked_binned_histogram_16bit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the masked binned histogram
// Clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef MASKED_BINNED_HISTOGRAM_16BIT_MACROS_SVH
`define MASKED_BINNED_HISTOGRAM_16BIT_MACROS_SVH

// same-cycle implication
`define MBH_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mbh_pkg.sv @@
// ----------------------------------------------------------------------------
// mbh_pkg
// Types and constants shared by the masked binned histogram modules.
// ----------------------------------------------------------------------------
package mbh_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR      = 2'd0,
    REQ_PIXEL      = 2'd1,
    REQ_READ_BIN   = 2'd2,
    REQ_READ_STATS = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_RANGE_LOW    = 2'd0,
    REG_RANGE_HIGH   = 2'd1,
    REG_BIN_WIDTH    = 2'd2,
    REG_REGION_LABEL = 2'd3
  } reg_index_t;

  localparam logic KIND_BIN   = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  localparam logic [15:0] MIN_INIT      = 16'hFFFF;
  localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;
  localparam logic [8:0]  BIN_WIDTH_MAX = 9'd256;

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LIM   = 8'b0000_0100,
    S_IDX   = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_BIN   = 8'b0010_0000,
    S_MEAN  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [15:0] low;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/masked_binned_histogram_16bit.sv @@
// ----------------------------------------------------------------------------
// masked_binned_histogram_16bit
// Masked pixel histogram with running min, max, count, sum and mean.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset and after every clear request
// the bin memory is swept to zero, one bin per cycle, during which in_ready is
// low. A counted pixel goes through the shared 16-step divider, and through it
// once more before that when it is the first one after reset or after any
// configuration write (the last bin index is then recomputed), followed by a
// read and a write-back of the bin memory. A pixel that is not counted leaves
// the block idle. A bin read goes through a registered read of the bin memory
// unless the select is at or above MAX_BINS; a statistics read computes the
// mean through the divider unless nothing has been counted; each then waits
// in S_OUT while a previous result has not been taken. Configuration writes
// are always taken.
// ----------------------------------------------------------------------------
module masked_binned_histogram_16bit #(
  parameter int MAX_BINS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] pixel_value,
  input  logic [15:0] mask_label,
  input  logic [11:0] bin_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [31:0] bin_total,
  output logic [15:0] value_min,
  output logic [15:0] value_max,
  output logic [31:0] pixel_total,
  output logic [15:0] value_mean,
  output logic        is_empty
);
  import mbh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);
  localparam logic [16:0]   BINS_EXT  = 17'(MAX_BINS);
  localparam logic [16:0]   LAST_EXT  = 17'(MAX_BINS - 1);

  state_t state, state_next;

  logic [AW-1:0] clr_addr;
  logic [15:0]   range_low;
  logic [15:0]   range_high;
  logic [8:0]    bin_width;
  logic [15:0]   region_label;
  logic          lim_ok;
  logic [AW-1:0] lim;
  logic [15:0]   pix_q;
  logic [AW-1:0] bin_addr;
  logic [15:0]   run_min;
  logic [15:0]   run_max;
  logic [31:0]   run_count;
  logic [47:0]   run_sum;
  logic          res_kind;
  logic [31:0]   res_bin;
  logic [15:0]   res_mean;

  logic          accept;
  logic          counted;
  logic [8:0]    w_eff;
  logic [15:0]   span_d;
  logic [15:0]   pix_src;
  logic [15:0]   pix_off;
  logic [15:0]   q;
  logic [AW-1:0] lim_cand;
  logic [AW-1:0] idx;
  logic          sel_ok;
  logic          out_free;
  logic [31:0]   bin_inc;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [31:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [31:0]   mem_rd_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    counted = (region_label == '0) || (mask_label == region_label);
    priority if (bin_width == '0) begin
      w_eff = 9'd1;
    end else if (bin_width > BIN_WIDTH_MAX) begin
      w_eff = BIN_WIDTH_MAX;
    end else begin
      w_eff = bin_width;
    end
    span_d   = (range_high <= range_low) ? 16'd1 : range_high - range_low;
    pix_src  = (state == S_IDLE) ? pixel_value : pix_q;
    pix_off  = (pix_src > range_low) ? pix_src - range_low : 16'd0;
    q        = div_rsp.quotient;
    lim_cand = ({1'b0, q} > LAST_EXT) ? LAST_ADDR : AW'(q);
    idx      = (q > 16'(lim)) ? lim : AW'(q);
    sel_ok   = {5'b0, bin_select} < BINS_EXT;
    bin_inc  = (mem_rd_data == CNT_MAX) ? mem_rd_data : mem_rd_data + 32'd1;
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.rem_init = '0;
    div_req.low = pix_off;
    div_req.divisor = {23'b0, w_eff};
    priority if (accept && req_type == REQ_READ_STATS) begin
      div_req.start    = (run_count != '0);
      div_req.rem_init = run_sum[47:16];
      div_req.low      = run_sum[15:0];
      div_req.divisor  = run_count;
    end else if (accept && req_type == REQ_PIXEL) begin
      div_req.start = counted;
      if (!lim_ok) begin
        div_req.low = span_d;
      end
    end else if (state == S_LIM) begin
      div_req.start = div_rsp.done;
    end else begin
      div_req.start = 1'b0;
    end
  end

  always_comb begin
    mem_wr_en   = (state == S_CLEAR) || (state == S_UPD);
    mem_wr_addr = (state == S_CLEAR) ? clr_addr : bin_addr;
    mem_wr_data = (state == S_CLEAR) ? 32'd0 : bin_inc;
    mem_rd_en   = ((state == S_IDX) && div_rsp.done)
                  || (accept && req_type == REQ_READ_BIN && sel_ok);
    mem_rd_addr = (state == S_IDX) ? idx : AW'(bin_select);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            REQ_CLEAR:      state_next = S_CLEAR;
            REQ_PIXEL:      state_next = !counted ? S_IDLE : (lim_ok ? S_IDX : S_LIM);
            REQ_READ_BIN:   state_next = sel_ok ? S_BIN : S_OUT;
            REQ_READ_STATS: state_next = (run_count != '0) ? S_MEAN : S_OUT;
            default:        state_next = S_IDLE;
          endcase
        end
      end
      S_LIM: begin
        if (div_rsp.done) state_next = S_IDX;
      end
      S_IDX: begin
        if (div_rsp.done) state_next = S_UPD;
      end
      S_UPD:  state_next = S_IDLE;
      S_BIN:  state_next = S_OUT;
      S_MEAN: begin
        if (div_rsp.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      range_low    <= 16'd0;
      range_high   <= 16'hFFFF;
      bin_width    <= 9'd1;
      region_label <= 16'd0;
      lim_ok       <= 1'b0;
      run_min      <= MIN_INIT;
      run_max      <= 16'd0;
      run_count    <= 32'd0;
      run_sum      <= 48'd0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + 1'b1;
      end
      if (cfg_valid) begin
        lim_ok <= 1'b0;
        unique case (cfg_index)
          REG_RANGE_LOW:    range_low    <= cfg_data;
          REG_RANGE_HIGH:   range_high   <= cfg_data;
          REG_BIN_WIDTH:    bin_width    <= cfg_data[8:0];
          REG_REGION_LABEL: region_label <= cfg_data;
          default: ;
        endcase
      end
      if (accept && req_type == REQ_CLEAR) begin
        run_min   <= MIN_INIT;
        run_max   <= 16'd0;
        run_count <= 32'd0;
        run_sum   <= 48'd0;
      end
      if (accept && req_type == REQ_PIXEL && counted) begin
        if (pixel_value > run_max) run_max <= pixel_value;
        if (pixel_value < run_min) run_min <= pixel_value;
        if (run_count != CNT_MAX) begin
          run_count <= run_count + 32'd1;
          run_sum   <= run_sum + 48'(pixel_value);
        end
      end
      if (state == S_LIM && div_rsp.done && !cfg_valid) begin
        lim_ok <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_PIXEL) begin
      pix_q <= pixel_value;
    end
    if (accept && req_type == REQ_READ_BIN) begin
      res_kind <= KIND_BIN;
      res_bin  <= 32'd0;
    end
    if (accept && req_type == REQ_READ_STATS) begin
      res_kind <= KIND_STATS;
      res_mean <= 16'd0;
    end
    if (state == S_LIM && div_rsp.done) begin
      lim <= lim_cand;
    end
    if (state == S_IDX && div_rsp.done) begin
      bin_addr <= idx;
    end
    if (state == S_BIN) begin
      res_bin <= mem_rd_data;
    end
    if (state == S_MEAN && div_rsp.done) begin
      res_mean <= q;
    end
    if (state == S_OUT && out_free) begin
      result_kind <= res_kind;
      if (res_kind == KIND_BIN) begin
        bin_total   <= res_bin;
        value_min   <= 16'd0;
        value_max   <= 16'd0;
        pixel_total <= 32'd0;
        value_mean  <= 16'd0;
        is_empty    <= 1'b0;
      end else begin
        bin_total   <= 32'd0;
        value_min   <= run_min;
        value_max   <= run_max;
        pixel_total <= run_count;
        value_mean  <= res_mean;
        is_empty    <= (run_count == '0);
      end
    end
  end

  mbh_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mbh_bin_mem #(
    .DEPTH (MAX_BINS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

`include "masked_binned_histogram_16bit_macros.svh"

  `MBH_ASSERT_NEXT(a_upd_addr, state == S_IDX && div_rsp.done, mem_wr_en && mem_wr_addr == $past(mem_rd_addr), "bin write-back address differs from read address")
  `MBH_ASSERT_IMPL(a_min_max, run_count != '0, run_min <= run_max, "running min above running max")
  `MBH_ASSERT_IMPL(a_empty, out_valid && result_kind == KIND_STATS, is_empty == (pixel_total == '0), "empty flag disagrees with pixel count")
  `MBH_ASSERT_IMPL(a_div_idle, in_ready, !div_rsp.busy, "divider busy while taking requests")

endmodule

@@ sv/mbh_bin_mem.sv @@
// ----------------------------------------------------------------------------
// mbh_bin_mem
// Bin count store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbh_bin_mem #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/mbh_divider.sv @@
// ----------------------------------------------------------------------------
// mbh_divider
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
module mbh_divider (
  input  logic             clk,
  input  logic             rst,
  input  mbh_pkg::div_req_t req,
  output mbh_pkg::div_rsp_t rsp
);
  import mbh_pkg::*;

  logic [31:0]          rem;
  logic [15:0]          quo;
  logic [31:0]          dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, quo[15]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      quo <= req.low;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      quo <= {quo[14:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
